// ===== sv/aiat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiat_pkg
// Shared types and constants for the aging IPv4 allowlist table.
// ----------------------------------------------------------------------------
package aiat_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TMO_W       = 16;
  localparam int unsigned CNT_OUT_W   = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd600;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_PURGE = 2'd2
  } aiat_req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 1'd0,
    CFG_TIMEOUT = 1'd1
  } aiat_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FIN
  } aiat_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] ip_addr;
    logic [TIME_W-1:0] now_secs;
  } aiat_req_t;

  typedef struct packed {
    logic                 hit;
    logic                 inserted;
    logic                 table_full;
    logic [CNT_OUT_W-1:0] live_count;
  } aiat_rsp_t;

  // verdict of the per-entry check unit
  typedef struct packed {
    logic stale;
    logic live;
    logic match;
  } aiat_eval_t;

endpackage

// ===== sv/aiat_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiat_eval
// Per-entry check unit, shared by every step of the table walk.
// ----------------------------------------------------------------------------
module aiat_eval (
  input  logic                         slot_vld,
  input  logic [aiat_pkg::ADDR_W-1:0]  slot_addr,
  input  logic [aiat_pkg::TIME_W-1:0]  slot_stamp,
  input  logic [aiat_pkg::TMO_W-1:0]   timeout,
  input  logic [aiat_pkg::TIME_W-1:0]  now,
  input  logic [aiat_pkg::ADDR_W-1:0]  ip,
  output aiat_pkg::aiat_eval_t         res
);
  import aiat_pkg::*;

  logic [TIME_W:0] deadline;

  // 33-bit sum, no wrap
  assign deadline  = {1'b0, slot_stamp} + {{(TIME_W + 1 - TMO_W){1'b0}}, timeout};
  assign res.stale = slot_vld && (deadline < {1'b0, now});
  assign res.live  = slot_vld && !res.stale;
  assign res.match = res.live && (slot_addr == ip);

endmodule

// ===== sv/aging_ip_allowlist_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_ip_allowlist_table_unit
// Aging IPv4 allowlist: when enabled, expiry walk, then check, add/refresh or purge.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request beat {req_type, ip_addr, now_secs}; taken when in_valid
//           is high and in_stall is low. in_stall stays high from the beat
//           until its result has been loaded into the output register.
//   out_* : one result beat {hit, inserted, table_full, live_count} per
//           request, held in an output register until out_stall is low.
//   cfg_* : register writes (index 0 enable, 1 timeout_secs); cfg_ready is
//           always high. Write only while no request is in flight.
// Sequence: enabled, a walk reads one entry of the address/stamp RAM per
//   cycle into the RAM read register, where the single staleness/compare
//   unit checks it; a drain step then empties the read stage and a commit
//   step loads the result. Disabled: the request goes straight to commit.
// Requests: one at a time; a new one is not taken until the last has
//   committed, as the walk uses the single RAM read port. A stalled output
//   delays the commit step, so the next request waits too.
// Reset: valid bits cleared, live count 0, enable 0, timeout 600. The RAM
//   is not cleared; a slot's contents are used only while its valid bit is set.
// ----------------------------------------------------------------------------
module aging_ip_allowlist_table_unit #(
  parameter int unsigned ENTRIES = aiat_pkg::ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  aiat_pkg::aiat_req_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output aiat_pkg::aiat_rsp_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aiat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aiat_pkg::TMO_W-1:0]       cfg_data
);
  import aiat_pkg::*;

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned MEMW = ADDR_W + TIME_W;

  // config
  logic              enable_r;
  logic [TMO_W-1:0]  timeout_r;

  // control
  aiat_state_t       state_r, state_nxt;
  aiat_req_t         req_r;
  logic [IW-1:0]     idx_r;
  logic              ev_vld_r;
  logic [IW-1:0]     ev_idx_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     acc_r;
  logic              match_fnd_r, free_fnd_r;
  logic [IW-1:0]     match_idx_r, free_idx_r;

  // RAM for {addr, stamp}
  logic [MEMW-1:0]   slot_mem [ENTRIES];
  logic [MEMW-1:0]   rd_q;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;

  // output register
  logic              out_valid_r;
  aiat_rsp_t         out_data_r;

  aiat_eval_t        ev;
  logic              accept, last_idx, out_free, commit;
  logic              do_ins, do_ref;
  logic [CW-1:0]     cnt_fin;
  aiat_rsp_t         rsp;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign last_idx  = (idx_r == IW'(ENTRIES - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_FIN) && out_free;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (aiat_cfg_idx_t'(cfg_index))
        CFG_ENABLE:  enable_r  <= cfg_data[0];
        CFG_TIMEOUT: timeout_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // shared check unit, fed from the RAM read stage
  aiat_eval u_eval (
    .slot_vld   (ev_vld_r && valid_r[ev_idx_r]),
    .slot_addr  (rd_q[MEMW-1:TIME_W]),
    .slot_stamp (rd_q[TIME_W-1:0]),
    .timeout    (timeout_r),
    .now        (req_r.now_secs),
    .ip         (req_r.ip_addr),
    .res        (ev)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = enable_r ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        if (last_idx) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // commit decision
  always_comb begin
    do_ref  = 1'b0;
    do_ins  = 1'b0;
    rsp     = '0;
    cnt_fin = cnt_r;
    if (enable_r) begin
      case (aiat_req_type_t'(req_r.req_type))
        REQ_ADD: begin
          if (match_fnd_r) begin
            do_ref  = 1'b1;
            rsp.hit = 1'b1;
          end else if (free_fnd_r) begin
            do_ins       = 1'b1;
            rsp.inserted = 1'b1;
          end else begin
            rsp.table_full = 1'b1;
          end
        end
        REQ_CHECK: rsp.hit = match_fnd_r;
        default:   ;
      endcase
      cnt_fin = acc_r + CW'(do_ins);
    end
    if (32'(cnt_fin) > 32'd31) rsp.live_count = CNT_OUT_W'(31);
    else                       rsp.live_count = CNT_OUT_W'(cnt_fin);
  end

  assign mem_we = commit && (do_ins || do_ref);
  assign mem_wa = do_ref ? match_idx_r : free_idx_r;

  // valid bits: cleared on expiry, set on insert
  always_comb begin
    valid_nxt = valid_r;
    if (ev.stale) valid_nxt[ev_idx_r] = 1'b0;
    if (commit && do_ins) valid_nxt[free_idx_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      ev_vld_r <= (state_r == ST_WALK);
      if (commit) begin
        cnt_r       <= cnt_fin;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk bookkeeping (payload, no reset needed)
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r       <= in_data;
      idx_r       <= '0;
      acc_r       <= '0;
      match_fnd_r <= 1'b0;
      free_fnd_r  <= 1'b0;
    end else begin
      if (state_r == ST_WALK && !last_idx) idx_r <= idx_r + IW'(1);
      if (ev_vld_r) begin
        acc_r <= acc_r + CW'(ev.live);
        if (ev.match && !match_fnd_r) begin
          match_fnd_r <= 1'b1;
          match_idx_r <= ev_idx_r;
        end
        if (!ev.live && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
          free_idx_r <= ev_idx_r;
        end
      end
    end
    ev_idx_r <= idx_r;
    if (commit) out_data_r <= rsp;
  end

  // address/stamp RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_wa] <= {req_r.ip_addr, req_r.now_secs};
    rd_q <= slot_mem[idx_r];
  end

endmodule

// ===== sv/aiat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aiat_checker
// Port-level checks for the allowlist table, bound to the top level.
// ----------------------------------------------------------------------------
module aiat_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input aiat_pkg::aiat_rsp_t  out_data
);
  import aiat_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // add outcomes are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.inserted && out_data.table_full) &&
                  !(out_data.hit && out_data.inserted) &&
                  !(out_data.hit && out_data.table_full))
    else $error("conflicting result flags");

  // a fresh insert is counted
  a_ins_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inserted |-> out_data.live_count != '0)
    else $error("insert with zero live count");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aging_ip_allowlist_table_unit aiat_checker u_aiat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
